// ===== src/mwsp_pkg.sv =====
// Shared types and constants for the mecanum wheel speed PID block.
// No dependencies; imported by every module under src.
`default_nettype none

package mwsp_pkg;

    localparam int WHEEL_COUNT        = 4;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int CMD_W   = 14;
    localparam int MEAS_W  = 16;
    localparam int TGT_W   = 16;
    localparam int ERR_W   = 17;
    localparam int D1_W    = 18;
    localparam int D2_W    = 19;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int ACC_W   = 16;
    localparam int DUTY_W  = 15;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000);

    // lanes whose direction bit reads 1 when the accumulator is non-negative
    localparam logic [WHEEL_COUNT-1:0] WHEEL_LEFT = 4'b0101;

    typedef enum logic [1:0] {
        WHEEL_FL = 2'd0,
        WHEEL_FR = 2'd1,
        WHEEL_RL = 2'd2,
        WHEEL_RR = 2'd3
    } t_wheel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP  = 2'd0,
        CFG_GAIN_INTEG = 2'd1,
        CFG_GAIN_DERIV = 2'd2,
        CFG_DUTY_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_prop;
        logic [GAIN_W-1:0]  gain_integ;
        logic [GAIN_W-1:0]  gain_deriv;
        logic [LIMIT_W-1:0] duty_limit;
    } t_cfg;

    // load strobes of the pipeline stages after the mixer
    typedef struct packed {
        logic ld_err;
        logic ld_prod;
        logic ld_sum;
        logic ld_out;
    } t_pipe_ctl;

endpackage

`default_nettype wire

// ===== src/mwsp_mix.sv =====
// Mecanum mixing stage: body command to four wheel targets, registered
// together with the measured speeds. Depends on mwsp_pkg.
`default_nettype none

module mwsp_mix
    import mwsp_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_ld,
    input  wire signed [CMD_W-1:0]  i_cmd_x,
    input  wire signed [CMD_W-1:0]  i_cmd_y,
    input  wire signed [CMD_W-1:0]  i_cmd_rot,
    input  wire signed [MEAS_W-1:0] i_meas [WHEEL_COUNT],
    output logic signed [TGT_W-1:0]  o_tgt  [WHEEL_COUNT],
    output logic signed [MEAS_W-1:0] o_meas [WHEEL_COUNT]
);

    logic signed [TGT_W-1:0] w_x, w_y, w_r;
    logic signed [TGT_W-1:0] n_tgt [WHEEL_COUNT];
    logic signed [TGT_W-1:0] r_tgt [WHEEL_COUNT];
    logic signed [MEAS_W-1:0] r_meas [WHEEL_COUNT];

    assign w_x = TGT_W'(i_cmd_x);
    assign w_y = TGT_W'(i_cmd_y);
    assign w_r = TGT_W'(i_cmd_rot);

    always_comb begin
        n_tgt[WHEEL_FL] = w_y + w_x - w_r;
        n_tgt[WHEEL_FR] = w_y - w_x + w_r;
        n_tgt[WHEEL_RL] = w_y - w_x - w_r;
        n_tgt[WHEEL_RR] = w_y + w_x + w_r;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            for (int k = 0; k < WHEEL_COUNT; k++) begin
                r_tgt[k]  <= n_tgt[k];
                r_meas[k] <= i_meas[k];
            end
        end
    end

    assign o_tgt  = r_tgt;
    assign o_meas = r_meas;

endmodule

`default_nettype wire

// ===== src/mwsp_lane.sv =====
// One incremental PID lane: error differences, gain products, sum, then
// accumulate with truncation toward zero and clamp. Depends on mwsp_pkg.
`default_nettype none

module mwsp_lane
    import mwsp_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  t_cfg                    i_cfg,
    input  wire signed [TGT_W-1:0]  i_tgt,
    input  wire signed [MEAS_W-1:0] i_meas,
    output logic signed [ACC_W-1:0] o_acc_next
);

    localparam int PROD_W = GAIN_W + 1 + D2_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int TOT_W  = SUM_W + 1;
    localparam logic signed [TOT_W-1:0] ROUND_ADJ =
        TOT_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // error history and accumulator
    logic signed [ERR_W-1:0] r_e1, r_e2;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [ERR_W-1:0] w_e;
    logic signed [D1_W-1:0]  w_d1;
    logic signed [D2_W-1:0]  w_d2;
    logic signed [ERR_W-1:0] r_e;
    logic signed [D1_W-1:0]  r_d1;
    logic signed [D2_W-1:0]  r_d2;

    logic signed [PROD_W-1:0] w_p_prop, w_p_integ, w_p_deriv;
    logic signed [PROD_W-1:0] r_p_prop, r_p_integ, r_p_deriv;
    logic signed [SUM_W-1:0]  r_sum;

    logic signed [TOT_W-1:0] w_tot, w_adj, w_q, w_lim;

    assign w_e  = ERR_W'(i_tgt) - ERR_W'(i_meas);
    assign w_d1 = D1_W'(w_e) - D1_W'(r_e1);
    assign w_d2 = D2_W'(w_e) - (D2_W'(r_e1) <<< 1) + D2_W'(r_e2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1 <= '0;
            r_e2 <= '0;
        end else if (i_ctl.ld_err) begin
            r_e1 <= w_e;
            r_e2 <= r_e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_err) begin
            r_e  <= w_e;
            r_d1 <= w_d1;
            r_d2 <= w_d2;
        end
    end

    assign w_p_prop  = $signed({1'b0, i_cfg.gain_prop})  * r_d1;
    assign w_p_integ = $signed({1'b0, i_cfg.gain_integ}) * r_e;
    assign w_p_deriv = $signed({1'b0, i_cfg.gain_deriv}) * r_d2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            r_p_prop  <= w_p_prop;
            r_p_integ <= w_p_integ;
            r_p_deriv <= w_p_deriv;
        end
        if (i_ctl.ld_sum) begin
            r_sum <= SUM_W'(r_p_prop) + SUM_W'(r_p_integ) + SUM_W'(r_p_deriv);
        end
    end

    // accumulator loop: scaled add, truncate toward zero, clamp
    assign w_tot = TOT_W'(r_sum) + (TOT_W'(r_acc) <<< GAIN_FRAC_BITS);
    assign w_adj = w_tot[TOT_W-1] ? (w_tot + ROUND_ADJ) : w_tot;
    assign w_q   = w_adj >>> GAIN_FRAC_BITS;
    assign w_lim = TOT_W'({1'b0, i_cfg.duty_limit});

    always_comb begin
        if (w_q <= -w_lim) begin
            o_acc_next = ACC_W'(-w_lim);
        end else if (w_q >= w_lim) begin
            o_acc_next = ACC_W'(w_lim);
        end else begin
            o_acc_next = ACC_W'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.ld_out) begin
            r_acc <= o_acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mwsp_merge.sv =====
// Merging stage: turns the four lane accumulators into duty magnitudes and
// direction bits in the output register. Depends on mwsp_pkg.
`default_nettype none

module mwsp_merge
    import mwsp_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_ld,
    input  wire signed [ACC_W-1:0]  i_acc [WHEEL_COUNT],
    output logic [OUT_DATA_W-1:0]   o_tdata
);

    logic [DUTY_W-1:0]      n_duty [WHEEL_COUNT];
    logic [WHEEL_COUNT-1:0] n_dir;
    logic [DUTY_W-1:0]      r_duty [WHEEL_COUNT];
    logic [WHEEL_COUNT-1:0] r_dir;

    always_comb begin
        for (int k = 0; k < WHEEL_COUNT; k++) begin
            n_duty[k] = i_acc[k][ACC_W-1] ? DUTY_W'(-i_acc[k]) : DUTY_W'(i_acc[k]);
            // left wheels show 1 for forward, right wheels 0
            n_dir[k]  = WHEEL_LEFT[k] ? ~i_acc[k][ACC_W-1] : i_acc[k][ACC_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_duty <= n_duty;
            r_dir  <= n_dir;
        end
    end

    always_comb begin
        for (int k = 0; k < WHEEL_COUNT; k++) begin
            o_tdata[k*(DUTY_W+1) +: DUTY_W]   = r_duty[k];
            o_tdata[k*(DUTY_W+1) + DUTY_W]    = r_dir[k];
        end
    end

endmodule

`default_nettype wire

// ===== src/mecanum_wheel_speed_pid_top.sv =====
// Mecanum four-wheel speed controller: one incremental PID lane per wheel.
// Uses mwsp_pkg, mwsp_mix, mwsp_lane and mwsp_merge.
//
// Each input transaction carries a body command (x, y, rotation) and four
// measured wheel speeds; its result transaction carries a duty magnitude and
// a direction bit per wheel. The path is five registers deep: mixing,
// error differences, gain products, product sum, then the accumulate /
// truncate / clamp step that loads the output register. The mixing register
// loads on the accepting edge. One transaction is taken every cycle unless
// output back-pressure has filled every stage; the rate is set by the
// per-wheel accumulator update, which feeds the accumulator register back
// through combinational logic. A stalled output holds the pipeline back
// only once every stage is full. Configuration writes are always taken
// (o_cfg_ready is high) and should be made while no transaction is in flight.
`default_nettype none

module mecanum_wheel_speed_pid_top
    import mwsp_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // cfg write channel
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata, low bit up: cmd_x[13:0], cmd_y[27:14], cmd_rot[41:28],
    // meas_front_left[57:42], meas_front_right[73:58], meas_rear_left[89:74],
    // meas_rear_right[105:90], zero pad [111:106]
    input  wire [IN_DATA_W-1:0]    i_s_axis_tdata,
    // output stream
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    // tdata, low bit up: duty_front_left[14:0], dir_front_left[15],
    // duty_front_right[30:16], dir_front_right[31], duty_rear_left[46:32],
    // dir_rear_left[47], duty_rear_right[62:48], dir_rear_right[63]
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata
);

    t_cfg      r_cfg;
    t_pipe_ctl w_ctl;

    logic r_v_mix, r_v_err, r_v_prod, r_v_sum, r_v_out;
    logic w_ld_mix;
    logic w_free_mix, w_free_err, w_free_prod, w_free_sum;

    logic signed [MEAS_W-1:0] w_meas_in [WHEEL_COUNT];
    logic signed [TGT_W-1:0]  w_tgt     [WHEEL_COUNT];
    logic signed [MEAS_W-1:0] w_meas    [WHEEL_COUNT];
    logic signed [ACC_W-1:0]  w_acc     [WHEEL_COUNT];

    // ---------------- configuration registers ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop  <= '0;
            r_cfg.gain_integ <= '0;
            r_cfg.gain_deriv <= '0;
            r_cfg.duty_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_PROP:  r_cfg.gain_prop  <= i_cfg_data;
                CFG_GAIN_INTEG: r_cfg.gain_integ <= i_cfg_data;
                CFG_GAIN_DERIV: r_cfg.gain_deriv <= i_cfg_data;
                CFG_DUTY_LIMIT: r_cfg.duty_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    // a stage loads when it holds something and the next one is free
    always_comb begin
        w_ctl.ld_out  = r_v_sum && (!r_v_out || i_m_axis_tready);
        w_free_sum    = !r_v_sum || w_ctl.ld_out;
        w_ctl.ld_sum  = r_v_prod && w_free_sum;
        w_free_prod   = !r_v_prod || w_ctl.ld_sum;
        w_ctl.ld_prod = r_v_err && w_free_prod;
        w_free_err    = !r_v_err || w_ctl.ld_prod;
        w_ctl.ld_err  = r_v_mix && w_free_err;
        w_free_mix    = !r_v_mix || w_ctl.ld_err;
        w_ld_mix      = i_s_axis_tvalid && w_free_mix;
    end

    assign o_s_axis_tready = w_free_mix;
    assign o_m_axis_tvalid = r_v_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mix  <= 1'b0;
            r_v_err  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            r_v_mix  <= w_ld_mix      || (r_v_mix  && !w_ctl.ld_err);
            r_v_err  <= w_ctl.ld_err  || (r_v_err  && !w_ctl.ld_prod);
            r_v_prod <= w_ctl.ld_prod || (r_v_prod && !w_ctl.ld_sum);
            r_v_sum  <= w_ctl.ld_sum  || (r_v_sum  && !w_ctl.ld_out);
            r_v_out  <= w_ctl.ld_out  || (r_v_out  && !i_m_axis_tready);
        end
    end

    // ---------------- datapath ----------------
    always_comb begin
        for (int k = 0; k < WHEEL_COUNT; k++) begin
            w_meas_in[k] = i_s_axis_tdata[3*CMD_W + k*MEAS_W +: MEAS_W];
        end
    end

    mwsp_mix u_mix (
        .i_clk     (i_clk),
        .i_ld      (w_ld_mix),
        .i_cmd_x   (i_s_axis_tdata[0 +: CMD_W]),
        .i_cmd_y   (i_s_axis_tdata[CMD_W +: CMD_W]),
        .i_cmd_rot (i_s_axis_tdata[2*CMD_W +: CMD_W]),
        .i_meas    (w_meas_in),
        .o_tgt     (w_tgt),
        .o_meas    (w_meas)
    );

    for (genvar g = 0; g < WHEEL_COUNT; g++) begin : g_lane
        mwsp_lane #(
            .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_cfg      (r_cfg),
            .i_tgt      (w_tgt[g]),
            .i_meas     (w_meas[g]),
            .o_acc_next (w_acc[g])
        );
    end

    mwsp_merge u_merge (
        .i_clk   (i_clk),
        .i_ld    (w_ctl.ld_out),
        .i_acc   (w_acc),
        .o_tdata (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for mecanum_wheel_speed_pid_top: random and directed
// wheel commands, per-wheel incremental PID prediction, stream back-pressure.
// Depends on mwsp_pkg and the RTL under src.
`timescale 1ns / 100ps

module tb_top;
    import mwsp_pkg::*;

    // input transaction layout, last field (cmd_x) in the low bits of tdata
    typedef struct packed {
        logic [5:0]               pad;
        logic signed [MEAS_W-1:0] meas_rr, meas_rl, meas_fr, meas_fl;
        logic signed [CMD_W-1:0]  cmd_rot, cmd_y, cmd_x;
    } t_wheel_cmd;

    typedef struct packed {
        logic              dir;
        logic [DUTY_W-1:0] duty;
    } t_wheel_drive;

    // lane 0 (front left) sits in the low 16 bits
    typedef t_wheel_drive [WHEEL_COUNT-1:0] t_motor_drive;

    localparam int HOLD_OFF_CYCLES = 150;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    mecanum_wheel_speed_pid_top #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS_DEF)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // predictor copy of the registers and per-wheel loop state
    int gain_p = 0;
    int gain_i = 0;
    int gain_d = 0;
    int duty_lim = int'(LIMIT_RESET);
    int err_last [WHEEL_COUNT] = '{default: 0};
    int err_prior [WHEEL_COUNT] = '{default: 0};
    int duty_acc [WHEEL_COUNT] = '{default: 0};

    string wheel_tag [WHEEL_COUNT] = '{"front_left", "front_right", "rear_left", "rear_right"};

    t_wheel_cmd   cmd_q[$];
    t_motor_drive drive_exp_q[$];
    int           cmds_queued = 0;
    int           cmds_accepted = 0;
    int           mismatch_count = 0;
    logic         cmd_taken = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         pressure_go = 1'b0;
    logic         pressure_done = 1'b0;
    int           hold_left = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("Mismatches found");
        $finish;
    end

    // one PID update per wheel; state advances exactly as the block's does
    task automatic predict_drive(input t_wheel_cmd c, output t_motor_drive r);
        longint tx, ty, tr, e, e1, e2, sum, q, mag;
        longint tgt [WHEEL_COUNT];
        longint meas [WHEEL_COUNT];
        tx = c.cmd_x;
        ty = c.cmd_y;
        tr = c.cmd_rot;
        tgt[WHEEL_FL] = ty + tx - tr;
        tgt[WHEEL_FR] = ty - tx + tr;
        tgt[WHEEL_RL] = ty - tx - tr;
        tgt[WHEEL_RR] = ty + tx + tr;
        meas[WHEEL_FL] = c.meas_fl;
        meas[WHEEL_FR] = c.meas_fr;
        meas[WHEEL_RL] = c.meas_rl;
        meas[WHEEL_RR] = c.meas_rr;
        for (int k = 0; k < WHEEL_COUNT; k++) begin
            e = tgt[k] - meas[k];
            e1 = err_last[k];
            e2 = err_prior[k];
            sum = longint'(duty_acc[k]) * (longint'(1) <<< GAIN_FRAC_BITS_DEF)
                + gain_p * (e - e1) + gain_i * e + gain_d * (e - 2 * e1 + e2);
            q = sum / (longint'(1) <<< GAIN_FRAC_BITS_DEF);  // truncates toward zero
            if (q <= -duty_lim) begin
                q = -duty_lim;
            end else if (q >= duty_lim) begin
                q = duty_lim;
            end
            duty_acc[k] = int'(q);
            err_prior[k] = int'(e1);
            err_last[k] = int'(e);
            mag = (q < 0) ? -q : q;
            r[k].duty = DUTY_W'(mag);
            r[k].dir = WHEEL_LEFT[k] ? (q >= 0) : (q < 0);
        end
    endtask

    // driver: new command presented once the current one is taken
    always @(negedge i_clk) begin
        if (!i_s_axis_tvalid || cmd_taken) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= cmd_q.pop_front();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver side, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (pressure_go && !pressure_done) begin
            pressure_done <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: register writes, accepted commands, result check
    always @(posedge i_clk) begin
        t_motor_drive exp_drive;
        t_motor_drive got_drive;
        cmd_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_PROP:  gain_p = int'(i_cfg_data);
                CFG_GAIN_INTEG: gain_i = int'(i_cfg_data);
                CFG_GAIN_DERIV: gain_d = int'(i_cfg_data);
                CFG_DUTY_LIMIT: duty_lim = int'(i_cfg_data[LIMIT_W-1:0]);
                default: ;
            endcase
        end
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            predict_drive(t_wheel_cmd'(i_s_axis_tdata), exp_drive);
            drive_exp_q.push_back(exp_drive);
            cmds_accepted++;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_drive = t_motor_drive'(o_m_axis_tdata);
            if (drive_exp_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, o_m_axis_tdata);
            end else begin
                exp_drive = drive_exp_q.pop_front();
                for (int k = 0; k < WHEEL_COUNT; k++) begin
                    if (got_drive[k].duty !== exp_drive[k].duty) begin
                        mismatch_count++;
                        $display("%0t: duty_%s expected %0d actual %0d", $time,
                                 wheel_tag[k], exp_drive[k].duty, got_drive[k].duty);
                    end
                    if (got_drive[k].dir !== exp_drive[k].dir) begin
                        mismatch_count++;
                        $display("%0t: dir_%s expected %0d actual %0d", $time,
                                 wheel_tag[k], exp_drive[k].dir, got_drive[k].dir);
                    end
                end
            end
        end
    end

    function automatic t_wheel_cmd make_cmd(input int x, input int y, input int r,
                                            input int fl, input int fr,
                                            input int rl, input int rr);
        t_wheel_cmd c;
        c = '0;
        c.cmd_x = CMD_W'(x);
        c.cmd_y = CMD_W'(y);
        c.cmd_rot = CMD_W'(r);
        c.meas_fl = MEAS_W'(fl);
        c.meas_fr = MEAS_W'(fr);
        c.meas_rl = MEAS_W'(rl);
        c.meas_rr = MEAS_W'(rr);
        return c;
    endfunction

    // a third of the commands are raw noise; the rest track their targets so the
    // accumulators spend time away from the clamp
    function automatic t_wheel_cmd random_cmd();
        int x, y, r;
        if ($urandom_range(2) == 0) begin
            return make_cmd($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
        end
        x = int'($urandom_range(4000)) - 2000;
        y = int'($urandom_range(4000)) - 2000;
        r = int'($urandom_range(4000)) - 2000;
        return make_cmd(x, y, r,
                        y + x - r + int'($urandom_range(400)) - 200,
                        y - x + r + int'($urandom_range(400)) - 200,
                        y - x - r + int'($urandom_range(400)) - 200,
                        y + x + r + int'($urandom_range(400)) - 200);
    endfunction

    task automatic push_cmd(input t_wheel_cmd c);
        cmd_q.push_back(c);
        cmds_queued++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    task automatic end_cfg();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (cmds_accepted != cmds_queued || drive_exp_q.size() != 0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_gain();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return CFG_DATA_W'($urandom_range(600));
        endcase
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] lim_word;
        int mode;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero gains give zero duty
        push_cmd(make_cmd(8191, -8192, 100, 32767, -32768, 5, -5));
        push_cmd(make_cmd(-1, 1, -1, 1000, -1000, 0, 0));
        wait_drained();

        write_reg(CFG_GAIN_PROP, 16'h0100);
        write_reg(CFG_GAIN_INTEG, 16'h0080);
        write_reg(CFG_GAIN_DERIV, 16'h0040);
        write_reg(CFG_DUTY_LIMIT, 16'h7FFF);
        end_cfg();
        push_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(8191, 8191, 8191, 0, 0, 0, 0));
        push_cmd(make_cmd(-8192, -8192, -8192, 0, 0, 0, 0));
        push_cmd(make_cmd(0, 0, 0, 32767, 32767, 32767, 32767));
        push_cmd(make_cmd(0, 0, 0, -32768, -32768, -32768, -32768));
        // largest positive and negative front-left wheel errors
        push_cmd(make_cmd(8191, 8191, -8192, -32768, -32768, -32768, -32768));
        push_cmd(make_cmd(-8192, -8192, 8191, 32767, 32767, 32767, 32767));
        push_cmd(make_cmd(-8192, 8191, 8191, -32768, 32767, -32768, 32767));
        push_cmd(make_cmd(8191, -8192, -8192, 32767, -32768, 32767, -32768));
        push_cmd(make_cmd(1, -1, 1, -1, 1, -1, 1));
        push_cmd(make_cmd(-1, -1, -1, 0, 0, 0, 0));
        wait_drained();

        // zero limit forces every accumulator to zero
        write_reg(CFG_GAIN_PROP, 16'hFFFF);
        write_reg(CFG_GAIN_INTEG, 16'hFFFF);
        write_reg(CFG_GAIN_DERIV, 16'hFFFF);
        write_reg(CFG_DUTY_LIMIT, 16'h0000);
        end_cfg();
        push_cmd(make_cmd(8191, 8191, 8191, -32768, 32767, -32768, 32767));
        push_cmd(make_cmd(-8192, -8192, -8192, 32767, -32768, 32767, -32768));
        push_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // top bit of the limit word is dropped; clamp hits both rails
        write_reg(CFG_DUTY_LIMIT, 16'h8000 | 16'd300);
        end_cfg();
        push_cmd(make_cmd(4000, 4000, 0, -20000, 20000, -20000, 20000));
        push_cmd(make_cmd(-4000, -4000, 0, 20000, -20000, 20000, -20000));
        push_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0));
        push_cmd(make_cmd(0, 0, 0, 1, -1, 1, -1));
        wait_drained();

        for (int seg = 0; seg < 8; seg++) begin
            mode = seg % 4;
            write_reg(CFG_GAIN_PROP, random_gain());
            write_reg(CFG_GAIN_INTEG, random_gain());
            write_reg(CFG_GAIN_DERIV, random_gain());
            case ($urandom_range(9))
                0: lim_word = '0;
                1: lim_word = 16'h7FFF;
                default: lim_word = CFG_DATA_W'($urandom_range(32767));
            endcase
            lim_word[CFG_DATA_W-1] = 1'($urandom_range(1));
            write_reg(CFG_DUTY_LIMIT, lim_word);
            end_cfg();
            send_idle_pct = (mode == 1) ? 79 : (mode == 3) ? 38 : 0;
            recv_stall_pct = (mode == 2) ? 79 : (mode == 3) ? 38 : 0;
            if (seg == 0)
                pressure_go = 1'b1;
            for (int n = 0; n < 50; n++)
                push_cmd(random_cmd());
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && drive_exp_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mwsp_pkg.sv
src/mwsp_mix.sv
src/mwsp_lane.sv
src/mwsp_merge.sv
src/mecanum_wheel_speed_pid_top.sv
verif/tb_top.sv
